// ===== design/binary_template_match_defines.svh =====
// Assertion macros used by the checker file of binary_template_match.
// No dependencies; the including module must provide clk and arst_n.
`ifndef BINARY_TEMPLATE_MATCH_DEFINES_SVH
`define BINARY_TEMPLATE_MATCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is active
`define BTM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("binary_template_match: assertion failed");

// Next-cycle implication, sampled on clk, off while reset is active
`define BTM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("binary_template_match: assertion failed");

`endif

// ===== design/btm_pkg.sv =====
// Package for binary_template_match: codes, register indexes, FSM and struct types.
// No dependencies; used by the top level, the sequencer, the score unit and the checker.
package btm_pkg;

	// default map limits
	localparam int SCENE_MAX_ROWS_DEF = 64;
	localparam int SCENE_MAX_COLS_DEF = 64;
	localparam int TEMPL_MAX_ROWS_DEF = 32;
	localparam int TEMPL_MAX_COLS_DEF = 32;

	// input operation codes (carried in tuser)
	localparam logic [1:0] OP_LOAD_SCENE = 2'd0;
	localparam logic [1:0] OP_LOAD_TEMPL = 2'd1;
	localparam logic [1:0] OP_START      = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SCENE_ROWS = 2'd0;
	localparam logic [1:0] REG_SCENE_COLS = 2'd1;
	localparam logic [1:0] REG_TEMPL_ROWS = 2'd2;
	localparam logic [1:0] REG_TEMPL_COLS = 2'd3;

	// register reset values
	localparam logic [6:0] RST_SCENE_ROWS = 7'd64;
	localparam logic [6:0] RST_SCENE_COLS = 7'd64;
	localparam logic [5:0] RST_TEMPL_ROWS = 6'd32;
	localparam logic [5:0] RST_TEMPL_COLS = 6'd32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_FINISH
	} state_t;

	// sequencer to score unit
	typedef struct packed {
		logic clear;   // new search: zero score and best
		logic acc_en;  // read data valid this cycle
		logic eval;    // placement score complete
	} ctrl_t;

	// status back to the sequencer
	typedef struct packed {
		logic hit;       // current placement agrees everywhere
		logic out_free;  // output register can take a result
	} stat_t;

endpackage

// ===== design/binary_template_match.sv =====
// Top level of binary_template_match: APB registers, map RAMs, sequencer, score unit.
// Depends on btm_pkg, btm_ram, btm_ctrl, btm_score.
//
// Channel   Dir  Accepted when            Payload
// s_*       in   s_tvalid & s_tready      tuser: operation; tdata: row, col, cell_req
// m_*       out  m_tvalid & m_tready      tuser: exact; tdata: pos_x, pos_y, best_score
// APB       in   psel&penable&pwrite      scene_rows, scene_cols, templ_rows, templ_cols
//
// Load beats are accepted one per cycle while idle. A start beat walks every placement,
//   ending early when an exact match ends the walk, or going straight to finish when
//   the sizes leave no placement; one scene cell and one template cell are compared per
//   cycle via the map read ports, with a drain and an eval state after each placement.
// s_tready is low from the start beat until the result is in the output register.
// A result waiting on m_tready does not block loads; the next search's result waits for it.
// Reset clears control and registers; map contents are undefined until loaded.
module binary_template_match
	import btm_pkg::*;
#(
	parameter int SCENE_MAX_ROWS = SCENE_MAX_ROWS_DEF,
	parameter int SCENE_MAX_COLS = SCENE_MAX_COLS_DEF,
	parameter int TEMPL_MAX_ROWS = TEMPL_MAX_ROWS_DEF,
	parameter int TEMPL_MAX_COLS = TEMPL_MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] row, [11:6] col, [12] cell_req
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [5:0] pos_x, [11:6] pos_y, [22:12] best_score
	output logic [0:0]  m_tuser,   // [0] exact
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SR_W   = (SCENE_MAX_ROWS > 1) ? $clog2(SCENE_MAX_ROWS) : 1;
	localparam int SC_W   = (SCENE_MAX_COLS > 1) ? $clog2(SCENE_MAX_COLS) : 1;
	localparam int TR_W   = (TEMPL_MAX_ROWS > 1) ? $clog2(TEMPL_MAX_ROWS) : 1;
	localparam int TC_W   = (TEMPL_MAX_COLS > 1) ? $clog2(TEMPL_MAX_COLS) : 1;
	localparam int FULL_W = $clog2(TEMPL_MAX_ROWS * TEMPL_MAX_COLS + 1);

	logic [6:0] scene_rows_q;
	logic [6:0] scene_cols_q;
	logic [5:0] templ_rows_q;
	logic [5:0] templ_cols_q;

	logic [5:0] in_row;
	logic [5:0] in_col;
	logic       in_bit;
	logic       accept;
	logic       scene_we;
	logic       templ_we;

	ctrl_t                ctl;
	stat_t                stat;
	logic                 finish;
	logic                 hit;
	logic [SR_W-1:0]      pr;
	logic [SC_W-1:0]      pc;
	logic [FULL_W-1:0]    full;
	logic [SR_W+SC_W-1:0] scene_raddr;
	logic [TR_W+TC_W-1:0] templ_raddr;
	logic                 scene_bit;
	logic                 templ_bit;
	logic [FULL_W-1:0]    best;
	logic [SR_W-1:0]      best_row;
	logic [SC_W-1:0]      best_col;
	logic                 exact;

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic        m_tuser_q;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_rows_q <= RST_SCENE_ROWS;
			scene_cols_q <= RST_SCENE_COLS;
			templ_rows_q <= RST_TEMPL_ROWS;
			templ_cols_q <= RST_TEMPL_COLS;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_SCENE_ROWS: scene_rows_q <= pwdata[6:0];
				REG_SCENE_COLS: scene_cols_q <= pwdata[6:0];
				REG_TEMPL_ROWS: templ_rows_q <= pwdata[5:0];
				REG_TEMPL_COLS: templ_cols_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SCENE_ROWS: prdata = 32'(scene_rows_q);
			REG_SCENE_COLS: prdata = 32'(scene_cols_q);
			REG_TEMPL_ROWS: prdata = 32'(templ_rows_q);
			REG_TEMPL_COLS: prdata = 32'(templ_cols_q);
			default:        prdata = '0;
		endcase
	end

	// load decode; out-of-range cells are dropped
	assign in_row   = s_tdata[5:0];
	assign in_col   = s_tdata[11:6];
	assign in_bit   = s_tdata[12];
	assign accept   = s_tvalid && s_tready;
	assign scene_we = accept && (s_tuser == OP_LOAD_SCENE)
		&& (32'(in_row) < SCENE_MAX_ROWS) && (32'(in_col) < SCENE_MAX_COLS);
	assign templ_we = accept && (s_tuser == OP_LOAD_TEMPL)
		&& (32'(in_row) < TEMPL_MAX_ROWS) && (32'(in_col) < TEMPL_MAX_COLS);

	btm_ram #(
		.WIDTH (1),
		.DEPTH (2 ** (SR_W + SC_W))
	) u_scene_ram (
		.clk   (clk),
		.we    (scene_we),
		.waddr ({SR_W'(in_row), SC_W'(in_col)}),
		.wdata (in_bit),
		.raddr (scene_raddr),
		.rdata (scene_bit)
	);

	btm_ram #(
		.WIDTH (1),
		.DEPTH (2 ** (TR_W + TC_W))
	) u_templ_ram (
		.clk   (clk),
		.we    (templ_we),
		.waddr ({TR_W'(in_row), TC_W'(in_col)}),
		.wdata (in_bit),
		.raddr (templ_raddr),
		.rdata (templ_bit)
	);

	assign stat.hit      = hit;
	assign stat.out_free = !m_tvalid_q || m_tready;

	btm_ctrl #(
		.SCENE_MAX_ROWS (SCENE_MAX_ROWS),
		.SCENE_MAX_COLS (SCENE_MAX_COLS),
		.TEMPL_MAX_ROWS (TEMPL_MAX_ROWS),
		.TEMPL_MAX_COLS (TEMPL_MAX_COLS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.op          (s_tuser),
		.scene_rows  (scene_rows_q),
		.scene_cols  (scene_cols_q),
		.templ_rows  (templ_rows_q),
		.templ_cols  (templ_cols_q),
		.stat        (stat),
		.ready       (s_tready),
		.finish      (finish),
		.ctl         (ctl),
		.pr          (pr),
		.pc          (pc),
		.full        (full),
		.scene_raddr (scene_raddr),
		.templ_raddr (templ_raddr)
	);

	btm_score #(
		.SCENE_MAX_ROWS (SCENE_MAX_ROWS),
		.SCENE_MAX_COLS (SCENE_MAX_COLS),
		.TEMPL_MAX_ROWS (TEMPL_MAX_ROWS),
		.TEMPL_MAX_COLS (TEMPL_MAX_COLS)
	) u_score (
		.clk       (clk),
		.ctl       (ctl),
		.scene_bit (scene_bit),
		.templ_bit (templ_bit),
		.pr        (pr),
		.pc        (pc),
		.full      (full),
		.hit       (hit),
		.best      (best),
		.best_row  (best_row),
		.best_col  (best_col),
		.exact     (exact)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {1'b0, 11'(best), 6'(best_row), 6'(best_col)};
			m_tuser_q <= exact;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

// ===== design/btm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/btm_score.sv =====
// Score unit: cell compare and agreement counter, plus best-placement tracking.
// Depends on btm_pkg.
module btm_score
	import btm_pkg::*;
#(
	parameter int SCENE_MAX_ROWS = SCENE_MAX_ROWS_DEF,
	parameter int SCENE_MAX_COLS = SCENE_MAX_COLS_DEF,
	parameter int TEMPL_MAX_ROWS = TEMPL_MAX_ROWS_DEF,
	parameter int TEMPL_MAX_COLS = TEMPL_MAX_COLS_DEF,
	localparam int SR_W   = (SCENE_MAX_ROWS > 1) ? $clog2(SCENE_MAX_ROWS) : 1,
	localparam int SC_W   = (SCENE_MAX_COLS > 1) ? $clog2(SCENE_MAX_COLS) : 1,
	localparam int FULL_W = $clog2(TEMPL_MAX_ROWS * TEMPL_MAX_COLS + 1)
) (
	input  logic              clk,
	input  ctrl_t             ctl,
	input  logic              scene_bit,
	input  logic              templ_bit,
	input  logic [SR_W-1:0]   pr,
	input  logic [SC_W-1:0]   pc,
	input  logic [FULL_W-1:0] full,
	output logic              hit,
	output logic [FULL_W-1:0] best,
	output logic [SR_W-1:0]   best_row,
	output logic [SC_W-1:0]   best_col,
	output logic              exact
);

	logic [FULL_W-1:0] score_q;
	logic [FULL_W-1:0] best_q;
	logic [SR_W-1:0]   brow_q;
	logic [SC_W-1:0]   bcol_q;
	logic              exact_q;

	assign hit = (score_q == full);

	// agreement counter: one cell per beat of read data
	always_ff @(posedge clk) begin
		if (ctl.clear || ctl.eval) begin
			score_q <= '0;
		end else if (ctl.acc_en && (scene_bit == templ_bit)) begin
			score_q <= score_q + 1'b1;
		end
	end

	// best placement so far; exact hit ends the search
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			best_q  <= '0;
			brow_q  <= '0;
			bcol_q  <= '0;
			exact_q <= 1'b0;
		end else if (ctl.eval && (hit || score_q > best_q)) begin
			best_q  <= score_q;
			brow_q  <= pr;
			bcol_q  <= pc;
			exact_q <= hit;
		end
	end

	assign best     = best_q;
	assign best_row = brow_q;
	assign best_col = bcol_q;
	assign exact    = exact_q;

endmodule

// ===== design/btm_ctrl.sv =====
// Search sequencer: walks placements and template cells, drives map read addresses.
// Depends on btm_pkg.
module btm_ctrl
	import btm_pkg::*;
#(
	parameter int SCENE_MAX_ROWS = SCENE_MAX_ROWS_DEF,
	parameter int SCENE_MAX_COLS = SCENE_MAX_COLS_DEF,
	parameter int TEMPL_MAX_ROWS = TEMPL_MAX_ROWS_DEF,
	parameter int TEMPL_MAX_COLS = TEMPL_MAX_COLS_DEF,
	localparam int SR_W   = (SCENE_MAX_ROWS > 1) ? $clog2(SCENE_MAX_ROWS) : 1,
	localparam int SC_W   = (SCENE_MAX_COLS > 1) ? $clog2(SCENE_MAX_COLS) : 1,
	localparam int TR_W   = (TEMPL_MAX_ROWS > 1) ? $clog2(TEMPL_MAX_ROWS) : 1,
	localparam int TC_W   = (TEMPL_MAX_COLS > 1) ? $clog2(TEMPL_MAX_COLS) : 1,
	localparam int SRN_W  = $clog2(SCENE_MAX_ROWS + 1),
	localparam int SCN_W  = $clog2(SCENE_MAX_COLS + 1),
	localparam int TRN_W  = $clog2(TEMPL_MAX_ROWS + 1),
	localparam int TCN_W  = $clog2(TEMPL_MAX_COLS + 1),
	localparam int FULL_W = $clog2(TEMPL_MAX_ROWS * TEMPL_MAX_COLS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [1:0]             op,
	input  logic [6:0]             scene_rows,
	input  logic [6:0]             scene_cols,
	input  logic [5:0]             templ_rows,
	input  logic [5:0]             templ_cols,
	input  stat_t                  stat,
	output logic                   ready,
	output logic                   finish,
	output ctrl_t                  ctl,
	output logic [SR_W-1:0]        pr,
	output logic [SC_W-1:0]        pc,
	output logic [FULL_W-1:0]      full,
	output logic [SR_W+SC_W-1:0]   scene_raddr,
	output logic [TR_W+TC_W-1:0]   templ_raddr
);

	state_t state_q, state_d;

	logic [SR_W-1:0]   pr_q;
	logic [SC_W-1:0]   pc_q;
	logic [TR_W-1:0]   tr_q;
	logic [TC_W-1:0]   tc_q;
	logic [FULL_W-1:0] full_q;
	logic              scan_s1;

	logic [SRN_W-1:0] h1;
	logic [SCN_W-1:0] w1;
	logic [TRN_W-1:0] h2;
	logic [TCN_W-1:0] w2;
	logic             dims_ok;
	logic             start;
	logic             last_col;
	logic             last_cell;
	logic             more_cols;
	logic             more_rows;

	// sizes saturated to the map limits
	always_comb begin
		h1 = (32'(scene_rows) > SCENE_MAX_ROWS) ? SRN_W'(SCENE_MAX_ROWS) : SRN_W'(scene_rows);
		w1 = (32'(scene_cols) > SCENE_MAX_COLS) ? SCN_W'(SCENE_MAX_COLS) : SCN_W'(scene_cols);
		h2 = (32'(templ_rows) > TEMPL_MAX_ROWS) ? TRN_W'(TEMPL_MAX_ROWS) : TRN_W'(templ_rows);
		w2 = (32'(templ_cols) > TEMPL_MAX_COLS) ? TCN_W'(TEMPL_MAX_COLS) : TCN_W'(templ_cols);
		dims_ok = (h1 != '0) && (w1 != '0) && (h2 != '0) && (w2 != '0)
			&& (32'(h2) <= 32'(h1)) && (32'(w2) <= 32'(w1));
	end

	// walk position tests
	assign start     = ready && in_valid && (op == OP_START);
	assign last_col  = (32'(tc_q) + 32'd1 == 32'(w2));
	assign last_cell = last_col && (32'(tr_q) + 32'd1 == 32'(h2));
	assign more_cols = (32'(pc_q) + 32'(w2) < 32'(w1));
	assign more_rows = (32'(pr_q) + 32'(h2) < 32'(h1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = dims_ok ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (last_cell) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.hit || (!more_cols && !more_rows)) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ready      = 1'b0;
		finish     = 1'b0;
		ctl.eval   = 1'b0;
		unique case (state_q)
			ST_IDLE:   ready    = 1'b1;
			ST_SCAN:   ;
			ST_DRAIN:  ;
			ST_EVAL:   ctl.eval = 1'b1;
			ST_FINISH: finish   = stat.out_free;
			default:   ;
		endcase
		ctl.clear  = start;
		ctl.acc_en = scan_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= (state_q == ST_SCAN);
		end
	end

	// placement and cell counters
	always_ff @(posedge clk) begin
		if (start) begin
			pr_q   <= '0;
			pc_q   <= '0;
			tr_q   <= '0;
			tc_q   <= '0;
			full_q <= FULL_W'(32'(h2) * 32'(w2));
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				tc_q <= '0;
				tr_q <= last_cell ? '0 : tr_q + 1'b1;
			end else begin
				tc_q <= tc_q + 1'b1;
			end
		end else if (state_q == ST_EVAL) begin
			if (more_cols) begin
				pc_q <= pc_q + 1'b1;
			end else begin
				pc_q <= '0;
				pr_q <= pr_q + 1'b1;
			end
		end
	end

	// map read addresses: scene cell under template cell, template cell
	assign scene_raddr = {SR_W'(32'(pr_q) + 32'(tr_q)), SC_W'(32'(pc_q) + 32'(tc_q))};
	assign templ_raddr = {tr_q, tc_q};

	assign pr   = pr_q;
	assign pc   = pc_q;
	assign full = full_q;

endmodule

// ===== design/btm_checker.sv =====
// Port-level checker for binary_template_match, bound to the top level.
// Depends on btm_pkg and binary_template_match_defines.svh.
`include "binary_template_match_defines.svh"

module btm_checker
	import btm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result beat holds
	`BTM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a start beat makes the block busy on the next cycle
	`BTM_ASSERT_NXT(a_start_busy, s_tvalid && s_tready && s_tuser == OP_START, !s_tready)

	// an exact match always carries a nonzero score
	`BTM_ASSERT_IMP(a_exact_score, m_tvalid && m_tuser[0], m_tdata[22:12] != 11'd0)

	// a zero score is reported at the origin
	`BTM_ASSERT_IMP(a_zero_origin, m_tvalid && m_tdata[22:12] == 11'd0, m_tdata[11:0] == 12'd0)

endmodule

bind binary_template_match btm_checker u_btm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
